// ===== hdl/md_message_padder_unit_defines.svh =====
// Assertion macros shared by the message padder modules.
// Depends on nothing; the asserting module must have i_clk and i_rst_n in scope.
`ifndef MD_MESSAGE_PADDER_UNIT_DEFINES_SVH
`define MD_MESSAGE_PADDER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only while the block is out of reset.
`define MDP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Checked at every clock edge, reset included.
`define MDP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define MDP_ASSERT(lbl, prop, msg)
`define MDP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/mdp_pkg.sv =====
// Types, constants and the word packing function of the message padder.
// Used by the controller, the datapath and the top level; no dependencies.
package mdp_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned WORD_BYTES  = 4;
    localparam int unsigned POS_W       = $clog2(BLOCK_BYTES);
    localparam int unsigned IDX_W       = $clog2(BLOCK_BYTES / WORD_BYTES);

    localparam logic [7:0]       PAD_MARKER     = 8'h80;
    localparam logic [6:0]       BITS_PER_BYTE  = 7'd8;
    localparam logic [IDX_W-1:0] LEN_FIRST_IDX  = IDX_W'(BLOCK_BYTES / WORD_BYTES - 2);
    localparam logic [IDX_W-1:0] LAST_WORD_IDX  = IDX_W'(BLOCK_BYTES / WORD_BYTES - 1);

    localparam logic MODE_BYTE   = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_LEN
    } t_state;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_BYTE,
        CMD_FIN_FIRST,
        CMD_PAD_ZERO,
        CMD_LEN_FIRST,
        CMD_LEN_LAST
    } t_dp_cmd;

    typedef struct packed {
        logic             out_free;
        logic             wrap;
        logic [IDX_W-1:0] word_idx;
    } t_dp_status;

    // b0 is the earliest byte of the word.
    function automatic logic [31:0] pack_word(input logic be, input logic [7:0] b0,
                                              input logic [7:0] b1, input logic [7:0] b2,
                                              input logic [7:0] b3);
        logic [31:0] w;
        if (be) begin
            w = {b0, b1, b2, b3};
        end else begin
            w = {b3, b2, b1, b0};
        end
        return w;
    endfunction

endpackage

// ===== hdl/mdp_ctrl.sv =====
// Sequencer of the message padder: accepts input transfers and steps the padding run.
// Depends on mdp_pkg and md_message_padder_unit_defines.svh.
`include "md_message_padder_unit_defines.svh"

module mdp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_mode,
    output logic               o_in_ready,
    input  mdp_pkg::t_dp_status i_status,
    output mdp_pkg::t_dp_cmd    o_cmd
);

    mdp_pkg::t_state r_state;
    mdp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mdp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = mdp_pkg::CMD_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            mdp_pkg::S_IDLE: begin
                o_in_ready = i_status.out_free;
                if (i_in_valid && i_status.out_free) begin
                    if (i_in_mode == mdp_pkg::MODE_FINISH) begin
                        o_cmd   = mdp_pkg::CMD_FIN_FIRST;
                        n_state = mdp_pkg::S_PAD;
                    end else begin
                        o_cmd = mdp_pkg::CMD_BYTE;
                    end
                end
            end
            mdp_pkg::S_PAD: begin
                if (i_status.out_free) begin
                    if (i_status.word_idx == mdp_pkg::LEN_FIRST_IDX && !i_status.wrap) begin
                        o_cmd   = mdp_pkg::CMD_LEN_FIRST;
                        n_state = mdp_pkg::S_LEN;
                    end else begin
                        o_cmd = mdp_pkg::CMD_PAD_ZERO;
                    end
                end
            end
            mdp_pkg::S_LEN: begin
                if (i_status.out_free) begin
                    o_cmd   = mdp_pkg::CMD_LEN_LAST;
                    n_state = mdp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mdp_pkg::S_IDLE;
            end
        endcase
    end

    `MDP_ASSERT(a_len_ends_run, (r_state == mdp_pkg::S_LEN && i_status.out_free) |=> (r_state == mdp_pkg::S_IDLE), "length run did not return to idle")
    `MDP_ASSERT(a_finish_starts_pad, (o_in_ready && i_in_valid && i_in_mode == mdp_pkg::MODE_FINISH) |=> (r_state == mdp_pkg::S_PAD), "finish did not start padding")
    `MDP_ASSERT(a_len_slot, (o_cmd == mdp_pkg::CMD_LEN_FIRST) |-> (i_status.word_idx == mdp_pkg::LEN_FIRST_IDX && !i_status.wrap), "length placed at wrong word")

endmodule

// ===== hdl/mdp_dpath.sv =====
// Datapath of the message padder: byte gathering, length count and output register.
// Depends on mdp_pkg and md_message_padder_unit_defines.svh.
`include "md_message_padder_unit_defines.svh"

module mdp_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    input  mdp_pkg::t_dp_cmd     i_cmd,
    input  logic [7:0]          i_data_byte,
    output mdp_pkg::t_dp_status  o_status,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [31:0]         o_out_word,
    output logic [mdp_pkg::IDX_W-1:0] o_out_idx,
    output logic                o_out_last
);

    logic                        r_be;
    logic [23:0]                 r_pend;
    logic [mdp_pkg::POS_W-1:0]   r_pos;
    logic [63:0]                 r_bitlen;
    logic                        r_wrap;
    logic                        r_out_valid;
    logic [31:0]                 r_out_word;
    logic [mdp_pkg::IDX_W-1:0]   r_out_idx;
    logic                        r_out_last;

    logic [23:0]                 n_pend;
    logic [mdp_pkg::POS_W-1:0]   n_pos;
    logic [63:0]                 n_bitlen;
    logic                        n_wrap;
    logic                        n_out_valid;
    logic [31:0]                 n_out_word;
    logic [mdp_pkg::IDX_W-1:0]   n_out_idx;
    logic                        n_out_last;

    logic [1:0]                  lane;
    logic [mdp_pkg::IDX_W-1:0]   cur_idx;
    logic                        out_free;
    logic [7:0]                  fin_b [4];

    assign lane     = r_pos[1:0];
    assign cur_idx  = r_pos[mdp_pkg::POS_W-1:2];
    assign out_free = !r_out_valid || i_out_ready;

    // Bytes of the word that carries the pad marker: gathered bytes below the
    // marker lane, zeros above it.
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            if (2'(j) < lane) begin
                fin_b[j] = r_pend[8*j +: 8];
            end else if (2'(j) == lane) begin
                fin_b[j] = mdp_pkg::PAD_MARKER;
            end else begin
                fin_b[j] = 8'h00;
            end
        end
    end

    always_comb begin
        n_pend      = r_pend;
        n_pos       = r_pos;
        n_bitlen    = r_bitlen;
        n_wrap      = r_wrap;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        n_out_idx   = r_out_idx;
        n_out_last  = r_out_last;
        case (i_cmd)
            mdp_pkg::CMD_BYTE: begin
                n_bitlen = r_bitlen + 64'(mdp_pkg::BITS_PER_BYTE);
                n_pos    = r_pos + mdp_pkg::POS_W'(1);
                if (lane == 2'd3) begin
                    n_out_valid = 1'b1;
                    n_out_word  = mdp_pkg::pack_word(r_be, r_pend[7:0], r_pend[15:8],
                                                     r_pend[23:16], i_data_byte);
                    n_out_idx   = cur_idx;
                    n_out_last  = 1'b0;
                    n_pend      = 24'h0;
                end else if (lane == 2'd0) begin
                    n_pend = {16'h0, i_data_byte};
                end else begin
                    n_pend[8*lane +: 8] = i_data_byte;
                end
            end
            mdp_pkg::CMD_FIN_FIRST: begin
                n_out_valid = 1'b1;
                n_out_word  = mdp_pkg::pack_word(r_be, fin_b[0], fin_b[1], fin_b[2], fin_b[3]);
                n_out_idx   = cur_idx;
                n_out_last  = 1'b0;
                n_pend      = 24'h0;
                n_pos       = {cur_idx + mdp_pkg::IDX_W'(1), 2'b00};
                // The marker word sits in the length slot: pad out a whole extra block.
                n_wrap      = (cur_idx == mdp_pkg::LEN_FIRST_IDX);
            end
            mdp_pkg::CMD_PAD_ZERO: begin
                n_out_valid = 1'b1;
                n_out_word  = 32'h0;
                n_out_idx   = cur_idx;
                n_out_last  = 1'b0;
                n_pos       = {cur_idx + mdp_pkg::IDX_W'(1), 2'b00};
                n_wrap      = 1'b0;
            end
            mdp_pkg::CMD_LEN_FIRST: begin
                n_out_valid = 1'b1;
                n_out_word  = r_be ? r_bitlen[63:32] : r_bitlen[31:0];
                n_out_idx   = cur_idx;
                n_out_last  = 1'b0;
                n_pos       = {cur_idx + mdp_pkg::IDX_W'(1), 2'b00};
            end
            mdp_pkg::CMD_LEN_LAST: begin
                n_out_valid = 1'b1;
                n_out_word  = r_be ? r_bitlen[31:0] : r_bitlen[63:32];
                n_out_idx   = cur_idx;
                n_out_last  = 1'b1;
                n_pos       = '0;
                n_bitlen    = 64'h0;
                n_pend      = 24'h0;
                n_wrap      = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_be        <= 1'b0;
            r_pend      <= 24'h0;
            r_pos       <= '0;
            r_bitlen    <= 64'h0;
            r_wrap      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_be <= i_cfg_wr_data;
            end
            r_pend      <= n_pend;
            r_pos       <= n_pos;
            r_bitlen    <= n_bitlen;
            r_wrap      <= n_wrap;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

    assign o_status.out_free = out_free;
    assign o_status.wrap     = r_wrap;
    assign o_status.word_idx = cur_idx;
    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_out_word;
    assign o_out_idx         = r_out_idx;
    assign o_out_last        = r_out_last;

    `MDP_ASSERT(a_last_is_block_end, (r_out_valid && r_out_last) |-> (r_out_idx == mdp_pkg::LAST_WORD_IDX), "message end not on last word of a block")
    `MDP_ASSERT(a_run_clears_state, (i_cmd == mdp_pkg::CMD_LEN_LAST) |=> (r_pos == '0 && r_bitlen == 64'h0), "state not cleared after length")
    `MDP_ASSERT(a_emit_needs_room, (i_cmd != mdp_pkg::CMD_NONE) |-> out_free, "word issued into a full output register")

endmodule

// ===== hdl/md_message_padder_unit.sv =====
// Top level of the message padder: stream ports, configuration port and wiring.
// Depends on mdp_pkg, mdp_ctrl and mdp_dpath.
//
// The message padder is the front end of an MD5 or SHA style hash. Message bytes
// come in one per input transfer (tuser low) and leave as 32-bit words, each tagged
// with its index within the 64-byte block and a block end flag, packed little-endian
// (first byte in bits 7..0) or big-endian (first byte in bits 31..24) as the
// configuration bit selects. A finish transfer (tuser high, tdata ignored) appends
// the 0x80 marker, zero-fills to the last eight bytes of a block, adding a whole
// extra block when the marker lands in the last eight bytes, and closes with the
// 64-bit message length in bits, modulo 2^64: low word first in little-endian mode,
// high word first in big-endian mode. tlast marks the final word, after which the
// padder is ready for a new message. Message bytes may stream in back to back;
// every fourth byte produces one output word. A finish transfer starts a run of
// 3 to 18 words, one per cycle when the sink keeps tready high, and no input is
// taken until the run has left; the run length and the single output register
// set this figure. Input is also held off while the output register holds a word
// that the sink has not taken. The configuration bit is written with i_cfg_wr_en
// and should change only between messages or while idle.
module md_message_padder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: bit 0 selects big-endian packing.
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] mode (0 byte, 1 finish)
    // Output stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] word
    output logic [4:0]  o_m_axis_tuser,   // [3:0] word_index, [4] block_end
    output logic        o_m_axis_tlast    // message_end
);

    mdp_pkg::t_dp_status            status;
    mdp_pkg::t_dp_cmd               cmd;
    logic [mdp_pkg::IDX_W-1:0]      out_idx;

    mdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_mode  (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mdp_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .i_data_byte   (i_s_axis_tdata),
        .o_status      (status),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_out_word    (o_m_axis_tdata),
        .o_out_idx     (out_idx),
        .o_out_last    (o_m_axis_tlast)
    );

    // Block end is the last word position of a block.
    assign o_m_axis_tuser = {out_idx == mdp_pkg::LAST_WORD_IDX, out_idx};

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the message padder: random and directed byte streams,
// with finish transfers, checked word by word against a padding predictor.
// Depends on mdp_pkg and md_message_padder_unit.
module testbench;

    localparam int CYCLE_LIMIT = 100000;
    localparam int SETTLE      = 20;   // cycles allowed for a byte that forms no word
    localparam int HOLD_CYCLES = 300;  // long receiver hold-off for the pressure phase
    localparam int PRINT_LIMIT = 50;

    // One input transfer: the mode bit travels in tuser, the byte in tdata.
    typedef struct packed {
        logic       mode;
        logic [7:0] data;
    } t_msg_item;

    // One output word with its tags, as the padder should emit it.
    typedef struct packed {
        logic [31:0]               word;
        logic [mdp_pkg::IDX_W-1:0] idx;
        logic                      blk_end;
        logic                      msg_end;
    } t_padded_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'h00;
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic [4:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    md_message_padder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),    // [7:0] data_byte
        .i_s_axis_tuser  (i_s_axis_tuser),    // [0] mode
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),    // [31:0] word
        .o_m_axis_tuser  (o_m_axis_tuser),    // [3:0] word_index, [4] block_end
        .o_m_axis_tlast  (o_m_axis_tlast)     // message_end
    );

    // Period of 12 time units.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Items still to be offered on the input, and words the padder still owes us.
    t_msg_item    input_backlog[$];
    t_padded_word words_due[$];

    // Idle and stall rates in percent; the stimulus process changes them per phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // The pressure process lowers tready for a long stretch once this is raised.
    logic pressure_armed = 1'b0;
    logic hold_off = 1'b0;

    int fail_count = 0;
    int cycle_count = 0;

    // Predictor state: the byte order bit plus the padder's own running state.
    logic                      big_endian = 1'b0;
    logic [23:0]               partial_word = '0;
    logic [mdp_pkg::POS_W-1:0] block_pos = '0;
    logic [63:0]               msg_bits = '0;

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
    endtask

    // Places one byte at the current block position. Every fourth byte closes a word,
    // which is packed in the current byte order and queued as the next word owed.
    function automatic void shift_in_byte(input logic [7:0] b);
        int           k;
        t_padded_word w;
        k = int'(block_pos[1:0]);
        if (k != mdp_pkg::WORD_BYTES - 1) begin
            if (k == 0) begin
                partial_word = '0;
            end
            partial_word[k*8 +: 8] = b;
        end else begin
            if (big_endian) begin
                w.word = {partial_word[7:0], partial_word[15:8], partial_word[23:16], b};
            end else begin
                w.word = {b, partial_word[23:16], partial_word[15:8], partial_word[7:0]};
            end
            w.idx = block_pos[mdp_pkg::POS_W-1:2];
            w.blk_end = (w.idx == mdp_pkg::LAST_WORD_IDX);
            w.msg_end = 1'b0;
            words_due.push_back(w);
            partial_word = '0;
        end
        block_pos = block_pos + 1'b1;
    endfunction

    // Works out the words that one accepted input transfer causes. A finish appends
    // the marker, zero-fills up to the length field (spilling into a further block
    // when the marker lands in the last eight bytes) and writes the bit count.
    function automatic void absorb_transfer(input logic mode, input logic [7:0] data);
        int i;
        int sh;
        if (mode == mdp_pkg::MODE_BYTE) begin
            msg_bits = msg_bits + 64'd8;
            shift_in_byte(data);
        end else begin
            shift_in_byte(mdp_pkg::PAD_MARKER);
            while (block_pos != {mdp_pkg::LEN_FIRST_IDX, 2'b00}) begin
                shift_in_byte(8'h00);
            end
            for (i = 0; i < 2 * mdp_pkg::WORD_BYTES; i++) begin
                sh = big_endian ? 8 * (2 * mdp_pkg::WORD_BYTES - 1 - i) : 8 * i;
                shift_in_byte(msg_bits[sh +: 8]);
            end
            words_due[words_due.size() - 1].msg_end = 1'b1;
            partial_word = '0;
            block_pos = '0;
            msg_bits = '0;
        end
    endfunction

    // Input driver. The transfer on the bus is folded into the predictor at the edge
    // where it is accepted; then the next item is offered unless the sender idles.
    always @(posedge i_clk) begin : feed_input
        t_msg_item nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                absorb_transfer(i_s_axis_tuser, i_s_axis_tdata);
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (input_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = input_backlog.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tuser <= nxt.mode;
                    i_s_axis_tdata <= nxt.data;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor. Each accepted word is compared with the oldest word owed,
    // field by field; the sink then stalls at random or during the hold-off.
    always @(posedge i_clk) begin : watch_output
        t_padded_word due;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (words_due.size() == 0) begin
                    report_mismatch($sformatf("word %08h arrived with none outstanding",
                                              o_m_axis_tdata));
                end else begin
                    due = words_due.pop_front();
                    if (o_m_axis_tdata !== due.word) begin
                        report_mismatch($sformatf("word %08h, want %08h",
                                                  o_m_axis_tdata, due.word));
                    end
                    if (o_m_axis_tuser[3:0] !== due.idx) begin
                        report_mismatch($sformatf("word index %0d, want %0d",
                                                  o_m_axis_tuser[3:0], due.idx));
                    end
                    if (o_m_axis_tuser[4] !== due.blk_end) begin
                        report_mismatch($sformatf("block end %b, want %b",
                                                  o_m_axis_tuser[4], due.blk_end));
                    end
                    if (o_m_axis_tlast !== due.msg_end) begin
                        report_mismatch($sformatf("message end %b, want %b",
                                                  o_m_axis_tlast, due.msg_end));
                    end
                end
            end
            i_m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, counted here, so that the padder fills up while the
    // sender keeps offering bytes and has to drop its own tready.
    initial begin : receiver_hold
        wait (pressure_armed);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // A hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic queue_item(input logic mode, input logic [7:0] data);
        t_msg_item it;
        it.mode = mode;
        it.data = data;
        input_backlog.push_back(it);
    endtask

    // A message of random bytes closed by a finish whose tdata is junk.
    task automatic queue_message(input int len);
        int i;
        for (i = 0; i < len; i++) begin
            queue_item(mdp_pkg::MODE_BYTE, 8'($urandom_range(0, 255)));
        end
        queue_item(mdp_pkg::MODE_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // Random messages filling the given number of transfers; the last message is cut
    // short to fit. Most are short; some are long enough to land the marker near the
    // end of a block.
    task automatic queue_messages(input int budget);
        int added;
        int len;
        int r;
        added = 0;
        while (added < budget) begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
                len = $urandom_range(0, 12);
            end else if (r < 8) begin
                len = $urandom_range(13, 40);
            end else begin
                len = $urandom_range(48, 64);
            end
            if (len > budget - added - 1) begin
                len = budget - added - 1;
            end
            queue_message(len);
            added += len + 1;
        end
    endtask

    // Waits until every queued item has been taken and every word owed has arrived,
    // then lets the padder settle in case a trailing byte is still in flight.
    task automatic wait_drained();
        while (input_backlog.size() != 0 || i_s_axis_tvalid || words_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Configuration writes only happen with the padder idle between messages.
    task automatic write_byte_order(input logic be);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= be;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        big_endian = be;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, little-endian, no idling: empty message, data byte extremes,
        // finish at word offsets 0, 1 and 3, and back-to-back finishes.
        write_byte_order(1'b0);
        queue_item(mdp_pkg::MODE_FINISH, 8'hFF);
        queue_item(mdp_pkg::MODE_BYTE, 8'h00);
        queue_item(mdp_pkg::MODE_FINISH, 8'h00);
        queue_item(mdp_pkg::MODE_BYTE, 8'hFF);
        queue_item(mdp_pkg::MODE_BYTE, 8'h00);
        queue_item(mdp_pkg::MODE_BYTE, 8'hA5);
        queue_item(mdp_pkg::MODE_BYTE, 8'h5A);
        queue_item(mdp_pkg::MODE_FINISH, 8'hA5);
        queue_item(mdp_pkg::MODE_BYTE, 8'h01);
        queue_item(mdp_pkg::MODE_BYTE, 8'h02);
        queue_item(mdp_pkg::MODE_BYTE, 8'h03);
        queue_item(mdp_pkg::MODE_BYTE, 8'h04);
        queue_item(mdp_pkg::MODE_BYTE, 8'h05);
        queue_item(mdp_pkg::MODE_FINISH, 8'h5A);
        queue_item(mdp_pkg::MODE_BYTE, 8'h12);
        queue_item(mdp_pkg::MODE_BYTE, 8'h34);
        queue_item(mdp_pkg::MODE_BYTE, 8'h56);
        queue_item(mdp_pkg::MODE_FINISH, 8'h00);
        queue_item(mdp_pkg::MODE_FINISH, 8'hFF);
        wait_drained();

        // No idling, little-endian. A 55-byte message must fit the marker and the
        // length into its own block.
        queue_message(55);
        queue_messages(6);
        wait_drained();

        // Sender idle most of the time, big-endian. At 56 bytes the marker spills the
        // length into an extra block.
        write_byte_order(1'b1);
        send_idle_pct = 78;
        recv_stall_pct = 0;
        queue_message(56);
        queue_messages(6);
        wait_drained();

        // Receiver stalling most of the time.
        send_idle_pct = 0;
        recv_stall_pct = 78;
        queue_messages(18);
        wait_drained();

        // Both sides idling now and then, back to little-endian.
        write_byte_order(1'b0);
        send_idle_pct = 27;
        recv_stall_pct = 27;
        queue_messages(18);
        wait_drained();

        // Pressure: the sink holds off for a long stretch while bytes keep coming.
        write_byte_order(1'b1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        pressure_armed = 1'b1;
        queue_message(24);
        queue_messages(5);
        wait_drained();
        while (hold_off) begin
            @(negedge i_clk);
        end
        wait_drained();

        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
